FILE: rtl/epc_pkg.sv
// elapsed play clock: shared widths, request codes and payload types
// no dependencies; used by the interfaces and every module of the block

package epc_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned REQ_W    = 3;
    localparam int unsigned CNT_W    = 8;
    localparam int unsigned CYC_W    = 28;
    localparam int unsigned SEC_W    = 23;
    localparam int unsigned ADJ_W    = 10;
    localparam int unsigned PASSED_W = 32;

    localparam int unsigned MS_PER_CYCLE   = 25;
    localparam int unsigned MS_PER_SECOND  = 1000;
    localparam int unsigned SEC_PER_DAY    = 86400;
    localparam int unsigned SEC_PER_HOUR   = 3600;
    localparam int unsigned SEC_PER_MIN    = 60;
    localparam int unsigned MIN_PER_HOUR   = 60;
    localparam int unsigned HOUR_PER_DAY   = 24;
    localparam int unsigned MAX_SEC        = 59;
    localparam int unsigned MAX_HOUR       = 23;

    localparam logic [REQ_W-1:0] REQ_UPDATE       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE_SEC    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RESET        = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR_CYCLES = 3'd3;
    localparam logic [REQ_W-1:0] REQ_WRITE_MIN    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_WRITE_HOUR   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_WRITE_DAY    = 3'd6;

    // a second number split into days, hours, minutes and seconds
    typedef struct packed {
        logic [5:0] d;
        logic [4:0] h;
        logic [5:0] m;
        logic [5:0] s;
    } epc_dhms_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [CNT_W-1:0] wv;
        logic [CYC_W-1:0] cyc;
        logic [ADJ_W-1:0] sub_ms;
    } epc_ctl_t;

    typedef struct packed {
        epc_ctl_t  ctl;
        epc_dhms_t sec_now;
        epc_dhms_t sec_prev;
    } epc_split_t;

endpackage

FILE: rtl/epc_ifs.sv
// elapsed play clock: valid/ready channel interfaces for items and results
// depends on epc_pkg

interface epc_item_if;
    import epc_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [TIME_W-1:0]   play_time_ms;
    logic [CNT_W-1:0]    write_value;

    modport source (output valid, req_type, play_time_ms, write_value, input ready);
    modport sink   (input valid, req_type, play_time_ms, write_value, output ready);
endinterface

interface epc_result_if;
    import epc_pkg::*;

    logic                valid;
    logic                ready;
    logic [CNT_W-1:0]    seconds_out;
    logic [CNT_W-1:0]    minutes_out;
    logic [CNT_W-1:0]    hours_out;
    logic [CNT_W-1:0]    days_out;
    logic [PASSED_W-1:0] passed_cycles_out;

    modport source (output valid, seconds_out, minutes_out, hours_out, days_out,
                    passed_cycles_out, input ready);
    modport sink   (input valid, seconds_out, minutes_out, hours_out, days_out,
                    passed_cycles_out, output ready);
endinterface

FILE: rtl/epc_time_split.sv
// elapsed play clock: state-free front pipeline, splits the time stamp into
// cycle number, second number (days/hours/minutes/seconds) and sub-second ms
// depends on epc_pkg and epc_item_if

module epc_time_split (
    input  logic                clk,
    input  logic                rst_n,
    epc_item_if.sink            item,
    output epc_pkg::epc_split_t split_item,
    output logic                split_valid,
    input  logic                split_ready
);
    import epc_pkg::*;

    localparam int unsigned STAGES = 9;

    // reciprocal constants, exact over the full input range
    localparam logic [31:0] DIV25_MUL      = 32'h51EB_851F;
    localparam int unsigned DIV25_SHIFT    = 35;
    localparam logic [28:0] DIV1000_MUL    = 29'h1062_4DD3;
    localparam int unsigned DIV1000_SHIFT  = 38;
    localparam logic [23:0] DIV86400_MUL   = 24'd12725830;
    localparam int unsigned DIV86400_SHIFT = 40;
    localparam logic [17:0] DIV3600_MUL    = 18'd149131;
    localparam int unsigned DIV3600_SHIFT  = 29;
    localparam logic [12:0] DIV60_MUL      = 13'd4370;
    localparam int unsigned DIV60_SHIFT    = 18;

    localparam int unsigned REM1_W = 17;
    localparam int unsigned REM2_W = 12;

    function automatic epc_dhms_t dec_dhms(input epc_dhms_t v);
        epc_dhms_t r;
        r = v;
        if (v != '0)
        begin
            if (v.s != '0)
            begin
                r.s = v.s - 6'd1;
            end
            else
            begin
                r.s = 6'(MAX_SEC);
                if (v.m != '0)
                begin
                    r.m = v.m - 6'd1;
                end
                else
                begin
                    r.m = 6'(MAX_SEC);
                    if (v.h != '0)
                    begin
                        r.h = v.h - 5'd1;
                    end
                    else
                    begin
                        r.h = 5'(MAX_HOUR);
                        r.d = v.d - 6'd1;
                    end
                end
            end
        end
        return r;
    endfunction

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   load;

    // stage 0: input register
    logic [REQ_W-1:0]  req0_reg;
    logic [CNT_W-1:0]  wv0_reg;
    logic [TIME_W-1:0] t0_reg;

    // stage 1: cycle and second numbers
    logic [63:0]       cyc_prod;
    logic [63:0]       q_prod;
    logic [REQ_W-1:0]  req1_reg;
    logic [CNT_W-1:0]  wv1_reg;
    logic [ADJ_W-1:0]  tlo1_reg;
    logic [CYC_W-1:0]  cyc1_reg;
    logic [SEC_W-1:0]  q1_reg;

    // stage 2: sub-second ms and whole days
    logic [ADJ_W-1:0]  q_ms_lo;
    logic [ADJ_W-1:0]  sub_ms;
    logic [46:0]       qd_prod;
    epc_ctl_t          ctl_reg [2:STAGES-1];
    logic [SEC_W-1:0]  q2_reg;
    logic [5:0]        qd_reg [2:6];

    // stages 3 to 7: hours, minutes and seconds of the day
    logic [REM1_W-1:0] rem1;
    logic [REM1_W-1:0] rem1_reg [3:4];
    logic [34:0]       qh_prod;
    logic [4:0]        qh_reg [4:6];
    logic [REM2_W-1:0] rem2;
    logic [REM2_W-1:0] rem2_reg [5:6];
    logic [24:0]       qm_prod;
    logic [5:0]        qm6_reg;
    logic [5:0]        qs;
    epc_dhms_t         now7_reg;

    // stage 8: second number one lower, for a borrow from the adjust
    epc_dhms_t         now8_reg;
    epc_dhms_t         prev8_reg;

    always_comb
    begin
        load[STAGES] = split_ready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    assign item.ready = load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= item.valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (load[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign cyc_prod = 64'(t0_reg) * 64'(DIV25_MUL);
    assign q_prod   = 64'(t0_reg) * 64'(DIV1000_MUL);
    assign q_ms_lo  = q1_reg[ADJ_W-1:0] * ADJ_W'(MS_PER_SECOND);
    assign sub_ms   = tlo1_reg - q_ms_lo;
    assign qd_prod  = 47'(q1_reg) * 47'(DIV86400_MUL);
    assign rem1     = REM1_W'(q2_reg) - REM1_W'(qd_reg[2] * REM1_W'(SEC_PER_DAY));
    assign qh_prod  = 35'(rem1_reg[3]) * 35'(DIV3600_MUL);
    assign rem2     = REM2_W'(rem1_reg[4] - REM1_W'(qh_reg[4] * REM1_W'(SEC_PER_HOUR)));
    assign qm_prod  = 25'(rem2_reg[5]) * 25'(DIV60_MUL);
    assign qs       = 6'(rem2_reg[6] - REM2_W'(qm6_reg * REM2_W'(SEC_PER_MIN)));

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            req0_reg <= item.req_type;
            wv0_reg  <= item.write_value;
            t0_reg   <= item.play_time_ms;
        end
        if (load[1])
        begin
            req1_reg <= req0_reg;
            wv1_reg  <= wv0_reg;
            tlo1_reg <= t0_reg[ADJ_W-1:0];
            cyc1_reg <= cyc_prod[DIV25_SHIFT +: CYC_W];
            q1_reg   <= q_prod[DIV1000_SHIFT +: SEC_W];
        end
        if (load[2])
        begin
            ctl_reg[2] <= '{req: req1_reg, wv: wv1_reg, cyc: cyc1_reg, sub_ms: sub_ms};
            q2_reg     <= q1_reg;
            qd_reg[2]  <= qd_prod[DIV86400_SHIFT +: 6];
        end
        for (int i = 3; i < STAGES; i++)
        begin
            if (load[i])
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
        if (load[3])
        begin
            qd_reg[3]   <= qd_reg[2];
            rem1_reg[3] <= rem1;
        end
        if (load[4])
        begin
            qd_reg[4]   <= qd_reg[3];
            rem1_reg[4] <= rem1_reg[3];
            qh_reg[4]   <= qh_prod[DIV3600_SHIFT +: 5];
        end
        if (load[5])
        begin
            qd_reg[5]   <= qd_reg[4];
            qh_reg[5]   <= qh_reg[4];
            rem2_reg[5] <= rem2;
        end
        if (load[6])
        begin
            qd_reg[6]   <= qd_reg[5];
            qh_reg[6]   <= qh_reg[5];
            rem2_reg[6] <= rem2_reg[5];
            qm6_reg     <= qm_prod[DIV60_SHIFT +: 6];
        end
        if (load[7])
        begin
            now7_reg <= '{d: qd_reg[6], h: qh_reg[6], m: qm6_reg, s: qs};
        end
        if (load[8])
        begin
            now8_reg  <= now7_reg;
            prev8_reg <= dec_dhms(now7_reg);
        end
    end

    assign split_item  = '{ctl: ctl_reg[STAGES-1], sec_now: now8_reg, sec_prev: prev8_reg};
    assign split_valid = valid_reg[STAGES-1];

endmodule

FILE: rtl/epc_counter_core.sv
// elapsed play clock: timer state, second stepping with carries, and the
// result register formed by the counter state itself
// depends on epc_pkg and epc_result_if

module epc_counter_core (
    input  logic                clk,
    input  logic                rst_n,
    input  epc_pkg::epc_split_t split_item,
    input  logic                split_valid,
    output logic                split_ready,
    epc_result_if.source        result
);
    import epc_pkg::*;

    typedef struct packed {
        logic [3:0]       carry;
        logic [CNT_W-1:0] rest;
    } wrap_t;

    function automatic wrap_t wrap_60(input logic [CNT_W-1:0] v);
        wrap_t w;
        w.carry = '0;
        w.rest  = v;
        for (int k = 1; k <= 255 / SEC_PER_MIN; k++)
        begin
            if (v >= CNT_W'(k * SEC_PER_MIN))
            begin
                w.carry = 4'(k);
                w.rest  = v - CNT_W'(k * SEC_PER_MIN);
            end
        end
        return w;
    endfunction

    function automatic wrap_t wrap_24(input logic [CNT_W-1:0] v);
        wrap_t w;
        w.carry = '0;
        w.rest  = v;
        for (int k = 1; k <= 255 / HOUR_PER_DAY; k++)
        begin
            if (v >= CNT_W'(k * HOUR_PER_DAY))
            begin
                w.carry = 4'(k);
                w.rest  = v - CNT_W'(k * HOUR_PER_DAY);
            end
        end
        return w;
    endfunction

    logic [CYC_W-1:0]    last_cyc_reg, last_cyc_next;
    epc_dhms_t           last_sec_reg, last_sec_next;
    logic [ADJ_W-1:0]    adj_reg, adj_next;
    logic [PASSED_W-1:0] passed_reg, passed_next;
    logic [CNT_W-1:0]    sec_reg, sec_next;
    logic [CNT_W-1:0]    min_reg, min_next;
    logic [CNT_W-1:0]    hour_reg, hour_next;
    logic [CNT_W-1:0]    day_reg, day_next;
    logic                out_valid_reg;

    epc_ctl_t            ctl;
    logic                take;
    logic                do_update;
    logic [CYC_W-1:0]    cyc_diff;
    logic                cyc_same;
    logic                cyc_fwd;
    epc_dhms_t           sec_sel;
    logic                sec_same;
    logic [6:0]          ds, dm, dd;
    logic [5:0]          dh;
    logic [5:0]          step_s, step_m;
    logic [4:0]          step_h;
    logic [CNT_W-1:0]    s1, m1, h1, d1, m2, h2, d2;
    wrap_t               ws, wm, wh;

    assign ctl         = split_item.ctl;
    assign split_ready = !out_valid_reg || result.ready;
    assign take        = split_valid && split_ready;
    assign do_update   = (ctl.req == REQ_UPDATE) || (ctl.req == REQ_WRITE_SEC);

    assign cyc_diff = ctl.cyc - last_cyc_reg;
    assign cyc_same = ctl.cyc == last_cyc_reg;
    assign cyc_fwd  = ctl.cyc > last_cyc_reg;

    // time less the adjust borrows a second when the ms part is below it
    assign sec_sel  = (ctl.sub_ms < adj_reg) ? split_item.sec_prev : split_item.sec_now;
    assign sec_same = sec_sel == last_sec_reg;

    // mixed-radix step, final borrow marks a backward second
    assign ds     = {1'b0, sec_sel.s} - {1'b0, last_sec_reg.s};
    assign step_s = ds[6] ? ds[5:0] + 6'(SEC_PER_MIN) : ds[5:0];
    assign dm     = {1'b0, sec_sel.m} - {1'b0, last_sec_reg.m} - 7'(ds[6]);
    assign step_m = dm[6] ? dm[5:0] + 6'(MIN_PER_HOUR) : dm[5:0];
    assign dh     = {1'b0, sec_sel.h} - {1'b0, last_sec_reg.h} - 6'(dm[6]);
    assign step_h = dh[5] ? dh[4:0] + 5'(HOUR_PER_DAY) : dh[4:0];
    assign dd     = {1'b0, sec_sel.d} - {1'b0, last_sec_reg.d} - 7'(dh[5]);

    assign s1 = sec_reg + CNT_W'(step_s);
    assign m1 = min_reg + CNT_W'(step_m);
    assign h1 = hour_reg + CNT_W'(step_h);
    assign d1 = day_reg + CNT_W'(dd[5:0]);
    assign ws = wrap_60(s1);
    assign m2 = m1 + CNT_W'(ws.carry);
    assign wm = wrap_60(m2);
    assign h2 = h1 + CNT_W'(wm.carry);
    assign wh = wrap_24(h2);
    assign d2 = d1 + CNT_W'(wh.carry);

    always_comb
    begin
        last_cyc_next = last_cyc_reg;
        last_sec_next = last_sec_reg;
        adj_next      = adj_reg;
        passed_next   = passed_reg;
        sec_next      = sec_reg;
        min_next      = min_reg;
        hour_next     = hour_reg;
        day_next      = day_reg;

        if (do_update && !cyc_same)
        begin
            last_cyc_next = ctl.cyc;
            last_sec_next = sec_sel;
            if (cyc_fwd)
            begin
                passed_next = passed_reg + PASSED_W'(cyc_diff);
            end
            if (!sec_same && !dd[6])
            begin
                sec_next  = ws.rest;
                min_next  = wm.rest;
                hour_next = wh.rest;
                day_next  = d2;
            end
        end

        unique case (ctl.req)
            REQ_WRITE_SEC:
            begin
                sec_next = ctl.wv;
                adj_next = ctl.sub_ms;
            end
            REQ_RESET:
            begin
                last_cyc_next = ctl.cyc;
                last_sec_next = split_item.sec_now;
                adj_next      = '0;
                passed_next   = '0;
            end
            REQ_CLEAR_CYCLES:
            begin
                passed_next = '0;
            end
            REQ_WRITE_MIN:
            begin
                min_next = ctl.wv;
            end
            REQ_WRITE_HOUR:
            begin
                hour_next = ctl.wv;
            end
            REQ_WRITE_DAY:
            begin
                day_next = ctl.wv;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cyc_reg  <= '0;
            last_sec_reg  <= '0;
            adj_reg       <= '0;
            passed_reg    <= '0;
            sec_reg       <= '0;
            min_reg       <= '0;
            hour_reg      <= '0;
            day_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (split_ready)
            begin
                out_valid_reg <= split_valid;
            end
            if (take)
            begin
                last_cyc_reg <= last_cyc_next;
                last_sec_reg <= last_sec_next;
                adj_reg      <= adj_next;
                passed_reg   <= passed_next;
                sec_reg      <= sec_next;
                min_reg      <= min_next;
                hour_reg     <= hour_next;
                day_reg      <= day_next;
            end
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.seconds_out       = sec_reg;
    assign result.minutes_out       = min_reg;
    assign result.hours_out         = hour_reg;
    assign result.days_out          = day_reg;
    assign result.passed_cycles_out = passed_reg;

endmodule

FILE: rtl/elapsed_play_clock.sv
// elapsed play clock: top level, front split pipeline and counter core
// depends on epc_pkg, epc_ifs, epc_time_split and epc_counter_core
//
//   channel  direction  modport  payload
//   item     in         sink     req_type, play_time_ms, write_value
//   result   out        source   seconds_out, minutes_out, hours_out,
//                                days_out, passed_cycles_out
//
// one transfer per cycle on each side while result.ready stays high; a result
// passes nine front stages, the first taking the item, then the counter registers
// stages 1 to 7 hold reciprocal multiplies and remainders, stage 8 a decrement
// a stalled result holds its stage; earlier stages keep filling bubbles
// reset is asynchronous; no clearing pass, the block is ready at once

module elapsed_play_clock (
    input  logic         clk,
    input  logic         rst_n,
    epc_item_if.sink     item,
    epc_result_if.source result
);
    import epc_pkg::*;

    epc_split_t split_item;
    logic       split_valid;
    logic       split_ready;

    epc_time_split u_split (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .split_item  (split_item),
        .split_valid (split_valid),
        .split_ready (split_ready)
    );

    epc_counter_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .split_item  (split_item),
        .split_valid (split_valid),
        .split_ready (split_ready),
        .result      (result)
    );

endmodule

FILE: tb/sv/elapsed_play_clock_test.sv
// elapsed play clock testbench: directed and random play-time items, scoreboard check
// depends on epc_pkg, epc_ifs and the elapsed_play_clock top level

module elapsed_play_clock_test;
    import epc_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    localparam int unsigned RANDOM_ITEMS = 1030;
    localparam int unsigned HOLD_AT      = 400;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 500000;

    typedef struct {
        logic [CNT_W-1:0]    sec;
        logic [CNT_W-1:0]    min;
        logic [CNT_W-1:0]    hour;
        logic [CNT_W-1:0]    day;
        logic [PASSED_W-1:0] passed;
    } play_counts_t;

    class clock_scoreboard;
        logic [CYC_W-1:0]    last_cyc = '0;
        logic [SEC_W-1:0]    last_sec = '0;
        logic [ADJ_W-1:0]    sub_adj  = '0;
        logic [PASSED_W-1:0] passed   = '0;
        logic [CNT_W-1:0]    sec_cnt  = '0;
        logic [CNT_W-1:0]    min_cnt  = '0;
        logic [CNT_W-1:0]    hour_cnt = '0;
        logic [CNT_W-1:0]    day_cnt  = '0;
        play_counts_t        expected_counts[$];
        int unsigned         errors   = 0;

        function void add_elapsed(input logic [31:0] step);
            logic [31:0] rest;
            logic [31:0] part;
            logic [CNT_W-1:0] s, m, h, d;
            s = sec_cnt;
            m = min_cnt;
            h = hour_cnt;
            d = day_cnt;
            part = step / SEC_PER_DAY;
            d = d + part[CNT_W-1:0];
            rest = step % SEC_PER_DAY;
            part = rest / SEC_PER_HOUR;
            h = h + part[CNT_W-1:0];
            rest = rest % SEC_PER_HOUR;
            part = rest / SEC_PER_MIN;
            m = m + part[CNT_W-1:0];
            rest = rest % SEC_PER_MIN;
            s = s + rest[CNT_W-1:0];
            // carry chain, each sum wraps at 256
            part = {24'd0, s} / SEC_PER_MIN;
            m = m + part[CNT_W-1:0];
            part = {24'd0, s} % SEC_PER_MIN;
            s = part[CNT_W-1:0];
            part = {24'd0, m} / MIN_PER_HOUR;
            h = h + part[CNT_W-1:0];
            part = {24'd0, m} % MIN_PER_HOUR;
            m = part[CNT_W-1:0];
            part = {24'd0, h} / HOUR_PER_DAY;
            d = d + part[CNT_W-1:0];
            part = {24'd0, h} % HOUR_PER_DAY;
            h = part[CNT_W-1:0];
            sec_cnt  = s;
            min_cnt  = m;
            hour_cnt = h;
            day_cnt  = d;
        endfunction

        function void advance_time(input logic [TIME_W-1:0] t);
            logic [31:0] cyc;
            logic [31:0] ms;
            logic [31:0] sec;
            cyc = t / MS_PER_CYCLE;
            if (cyc[CYC_W-1:0] == last_cyc)
                return;
            if (cyc[CYC_W-1:0] > last_cyc)
                passed = passed + (cyc - {4'd0, last_cyc});
            last_cyc = cyc[CYC_W-1:0];
            ms = (t >= {22'd0, sub_adj}) ? t - {22'd0, sub_adj} : 32'd0;
            sec = ms / MS_PER_SECOND;
            if (sec[SEC_W-1:0] == last_sec)
                return;
            if (sec[SEC_W-1:0] > last_sec)
                add_elapsed(sec - {9'd0, last_sec});
            last_sec = sec[SEC_W-1:0];
        endfunction

        function void note_item(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] t,
                                input logic [CNT_W-1:0] wv);
            logic [31:0] part;
            play_counts_t counts;
            case (req)
                REQ_UPDATE:
                begin
                    advance_time(t);
                end
                REQ_WRITE_SEC:
                begin
                    advance_time(t);
                    sec_cnt = wv;
                    part = t % MS_PER_SECOND;
                    sub_adj = part[ADJ_W-1:0];
                end
                REQ_RESET:
                begin
                    part = t / MS_PER_CYCLE;
                    last_cyc = part[CYC_W-1:0];
                    part = t / MS_PER_SECOND;
                    last_sec = part[SEC_W-1:0];
                    sub_adj = '0;
                    passed = '0;
                end
                REQ_CLEAR_CYCLES:
                begin
                    passed = '0;
                end
                REQ_WRITE_MIN:
                begin
                    min_cnt = wv;
                end
                REQ_WRITE_HOUR:
                begin
                    hour_cnt = wv;
                end
                REQ_WRITE_DAY:
                begin
                    day_cnt = wv;
                end
                default:
                begin
                end
            endcase
            counts.sec    = sec_cnt;
            counts.min    = min_cnt;
            counts.hour   = hour_cnt;
            counts.day    = day_cnt;
            counts.passed = passed;
            expected_counts.push_back(counts);
        endfunction

        function void check_result(input logic [CNT_W-1:0] s, input logic [CNT_W-1:0] m,
                                   input logic [CNT_W-1:0] h, input logic [CNT_W-1:0] d,
                                   input logic [PASSED_W-1:0] p);
            play_counts_t want;
            if (expected_counts.size() == 0)
            begin
                $display("%0t: result with nothing pending: sec %0d min %0d hour %0d day %0d passed %0d",
                         $time, s, m, h, d, p);
                errors++;
                return;
            end
            want = expected_counts.pop_front();
            if (s !== want.sec)
            begin
                $display("%0t: seconds expected %0d actual %0d", $time, want.sec, s);
                errors++;
            end
            if (m !== want.min)
            begin
                $display("%0t: minutes expected %0d actual %0d", $time, want.min, m);
                errors++;
            end
            if (h !== want.hour)
            begin
                $display("%0t: hours expected %0d actual %0d", $time, want.hour, h);
                errors++;
            end
            if (d !== want.day)
            begin
                $display("%0t: days expected %0d actual %0d", $time, want.day, d);
                errors++;
            end
            if (p !== want.passed)
            begin
                $display("%0t: passed cycles expected %0d actual %0d", $time, want.passed, p);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    epc_item_if   item_ch();
    epc_result_if result_ch();

    elapsed_play_clock dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    clock_scoreboard board;
    int unsigned sent_count  = 0;
    int unsigned taken_count = 0;
    int unsigned cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("elapsed_play_clock_test: errors");
            $finish;
        end
    end

    // stretches with no idling every fourth block of transfers
    function automatic int unsigned idle_cycles(input int unsigned idx);
        if ((idx / 128) % 4 == 1)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    task automatic send_item(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] t,
                             input logic [CNT_W-1:0] wv);
        int unsigned gap;
        gap = idle_cycles(sent_count);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.req_type     <= req;
        item_ch.play_time_ms <= t;
        item_ch.write_value  <= wv;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        board.note_item(req, t, wv);
        sent_count++;
    endtask

    initial
    begin
        int unsigned stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            // one long hold-off so the pipeline fills and stalls the input
            stall = (taken_count == HOLD_AT) ? HOLD_CYCLES : idle_cycles(taken_count);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid) @(posedge clk);
            board.check_result(result_ch.seconds_out, result_ch.minutes_out,
                               result_ch.hours_out, result_ch.days_out,
                               result_ch.passed_cycles_out);
            taken_count++;
        end
    end

    initial
    begin
        logic [TIME_W-1:0] cur_ms;
        logic [CNT_W-1:0]  wv;
        logic [31:0]       rnd;
        int unsigned       pick;
        int unsigned       step;
        int unsigned       made;

        board = new;
        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.req_type     <= REQ_UPDATE;
        item_ch.play_time_ms <= '0;
        item_ch.write_value  <= '0;
        result_ch.ready      <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_item(REQ_UPDATE, 32'd0, 8'd0);
        send_item(REQ_UPDATE, 32'd24, 8'hff);
        send_item(REQ_UPDATE, 32'd25, 8'd0);
        send_item(REQ_UPDATE, 32'd1000, 8'd0);
        send_item(REQ_WRITE_SEC, 32'd1500, 8'd59);
        send_item(REQ_UPDATE, 32'd2499, 8'd0);
        send_item(REQ_UPDATE, 32'd2500, 8'd0);
        send_item(REQ_WRITE_MIN, 32'd2500, 8'd255);
        send_item(REQ_WRITE_HOUR, 32'd2500, 8'd255);
        send_item(REQ_WRITE_DAY, 32'd2500, 8'd250);
        send_item(REQ_WRITE_SEC, 32'd2510, 8'd255);
        // out of range counters brought back by the carry
        send_item(REQ_UPDATE, 32'd3663510, 8'd0);
        // time going backwards
        send_item(REQ_UPDATE, 32'd100, 8'd0);
        send_item(REQ_UPDATE, 32'd150, 8'd0);
        // adjust above the time, clamped at zero
        send_item(REQ_WRITE_SEC, 32'd999, 8'd0);
        send_item(REQ_UPDATE, 32'd500, 8'd0);
        send_item(REQ_UPDATE, 32'hffff_ffff, 8'd0);
        send_item(REQ_RESET, 32'hffff_ffff, 8'd0);
        send_item(REQ_UPDATE, 32'd0, 8'd0);
        send_item(REQ_UPDATE, 32'hffff_ffff, 8'd0);
        send_item(REQ_CLEAR_CYCLES, 32'd0, 8'd0);
        send_item(REQ_UNUSED, 32'hffff_ffff, 8'hff);
        send_item(REQ_RESET, 32'd0, 8'd0);
        send_item(REQ_WRITE_DAY, 32'd0, 8'd0);
        send_item(REQ_UPDATE, 32'd90000000, 8'd0);

        // random part: mostly time moving forwards
        cur_ms = '0;
        made   = 0;
        while (made < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            rnd  = $urandom;
            wv   = ($urandom_range(0, 3) == 0) ? rnd[7:0] : rnd[7:0] % 8'd60;
            if (pick < 55)
            begin
                step = $urandom_range(0, 99);
                if (step < 60)
                    step = $urandom_range(0, 40);
                else if (step < 90)
                    step = $urandom_range(0, 3000);
                else if (step < 98)
                    step = $urandom_range(0, 4000000);
                else
                    step = $urandom_range(0, 200000000);
                cur_ms = cur_ms + step;
                send_item(REQ_UPDATE, cur_ms, wv);
            end
            else if (pick < 65)
            begin
                step   = $urandom_range(0, 2000);
                cur_ms = cur_ms + step;
                send_item(REQ_WRITE_SEC, cur_ms, wv);
            end
            else if (pick < 70)
                send_item(REQ_WRITE_MIN, cur_ms, wv);
            else if (pick < 74)
                send_item(REQ_WRITE_HOUR, cur_ms, wv);
            else if (pick < 78)
                send_item(REQ_WRITE_DAY, cur_ms, wv);
            else if (pick < 81)
            begin
                if ($urandom_range(0, 1) == 1)
                    cur_ms = $urandom;
                send_item(REQ_RESET, cur_ms, wv);
            end
            else if (pick < 84)
                send_item(REQ_CLEAR_CYCLES, cur_ms, wv);
            else if (pick < 90)
            begin
                step   = $urandom_range(0, 5000);
                cur_ms = (cur_ms > step) ? cur_ms - step : '0;
                send_item(REQ_UPDATE, cur_ms, wv);
            end
            else if (pick < 95)
            begin
                cur_ms = $urandom;
                send_item(REQ_UPDATE, cur_ms, wv);
            end
            if (pick >= 95)
                send_item(REQ_UNUSED, $urandom, wv);
            else
                made++;
        end
        item_ch.valid <= 1'b0;

        while (board.expected_counts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("elapsed_play_clock_test: clean");
        else
            $display("elapsed_play_clock_test: errors");
        $finish;
    end

endmodule
